// ===== rtl/pcsc_pkg.sv =====
// Shared types and constants for the per-class packet and byte counters.
// No dependencies; every other file of the block imports this package.
package pcsc_pkg;

   localparam int NUM_CLASSES = 15;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);
   localparam int CNT_W       = 32;
   localparam int STAMP_W     = 64;
   localparam int APB_ADDR_W  = 6;
   localparam int APB_DATA_W  = 64;

   localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(NUM_CLASSES - 1);

   // class indexes
   localparam int C_ANY     = 0;
   localparam int C_V4      = 1;
   localparam int C_V6      = 2;
   localparam int C_IN      = 3;
   localparam int C_OUT     = 4;
   localparam int C_TCP     = 5;
   localparam int C_UDP     = 6;
   localparam int C_ICMP    = 7;
   localparam int C_LOWPORT = 8;
   localparam int C_SYN     = 9;
   localparam int C_FIN     = 10;
   localparam int C_SYNACK  = 11;
   localparam int C_ACK     = 12;
   localparam int C_PSH     = 13;
   localparam int C_SERVER  = 14;

   // TCP flag bit positions
   localparam int FL_FIN = 0;
   localparam int FL_SYN = 1;
   localparam int FL_PSH = 3;
   localparam int FL_ACK = 4;

   localparam logic [1:0] DIR_IN    = 2'd0;
   localparam logic [1:0] DIR_OUT   = 2'd1;
   localparam logic [1:0] TR_TCP    = 2'd1;
   localparam logic [1:0] TR_UDP    = 2'd2;
   localparam logic [1:0] TR_ICMP   = 2'd3;
   localparam logic [3:0] IP_VER_4  = 4'd4;
   localparam logic [3:0] IP_VER_6  = 4'd6;

   localparam logic [15:0] LOW_PORT_MAX  = 16'd1024;
   localparam logic [15:0] EXCLUDED_PORT = 16'd22;

   // register indexes, taken from paddr[5:3]
   localparam logic [2:0] REG_V4_ADDR = 3'd0;
   localparam logic [2:0] REG_V4_EN   = 3'd1;
   localparam logic [2:0] REG_V6_HIGH = 3'd2;
   localparam logic [2:0] REG_V6_LOW  = 3'd3;
   localparam logic [2:0] REG_V6_EN   = 3'd4;

   typedef struct packed {
      logic [31:0] v4_addr;
      logic        v4_en;
      logic [63:0] v6_high;
      logic [63:0] v6_low;
      logic        v6_en;
   } pcsc_cfg_type;

   typedef struct packed {
      logic               count_en;
      logic               load_ts;
      logic               commit_ts;
      logic               rd_en;
      logic               rd_last;
      logic [CLASS_W-1:0] rd_idx;
   } pcsc_cmd_type;

   typedef struct packed {
      logic out_free;
   } pcsc_sts_type;

endpackage

// ===== rtl/pcsc_ifs.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on pcsc_pkg for the class index width.
interface pcsc_req_if import pcsc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] pkt_length;
   logic [1:0]  direction;
   logic        is_ip;
   logic [3:0]  ip_version;
   logic [1:0]  transport;
   logic [7:0]  tcp_ctl_bits;
   logic [15:0] remote_port;
   logic [63:0] remote_addr_high;
   logic [63:0] remote_addr_low;
   logic        addr_is_v6;
   logic [STAMP_W-1:0] new_timestamp;

   modport source (
      output valid, func, pkt_length, direction, is_ip, ip_version, transport,
             tcp_ctl_bits, remote_port, remote_addr_high, remote_addr_low,
             addr_is_v6, new_timestamp,
      input  ready
   );
   modport sink (
      input  valid, func, pkt_length, direction, is_ip, ip_version, transport,
             tcp_ctl_bits, remote_port, remote_addr_high, remote_addr_low,
             addr_is_v6, new_timestamp,
      output ready
   );
endinterface

interface pcsc_rsp_if import pcsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] category;
   logic [CNT_W-1:0]   packet_total;
   logic [CNT_W-1:0]   byte_total;
   logic [STAMP_W-1:0] interval_start;
   logic               last;

   modport source (
      output valid, category, packet_total, byte_total, interval_start, last,
      input  ready
   );
   modport sink (
      input  valid, category, packet_total, byte_total, interval_start, last,
      output ready
   );
endinterface

// ===== rtl/pcsc_csr.sv =====
// APB register file holding the server address match settings.
// Depends on pcsc_pkg for register indexes and the config struct.
module pcsc_csr import pcsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   output pcsc_cfg_type          cfg
);

   pcsc_cfg_type cfg_ff, cfg_in;
   logic [2:0]   reg_idx;
   logic         wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[APB_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_V4_ADDR: cfg_in.v4_addr = pwdata[31:0];
            REG_V4_EN:   cfg_in.v4_en   = pwdata[0];
            REG_V6_HIGH: cfg_in.v6_high = pwdata;
            REG_V6_LOW:  cfg_in.v6_low  = pwdata;
            REG_V6_EN:   cfg_in.v6_en   = pwdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_V4_ADDR: prdata = {32'd0, cfg_ff.v4_addr};
         REG_V4_EN:   prdata = {63'd0, cfg_ff.v4_en};
         REG_V6_HIGH: prdata = cfg_ff.v6_high;
         REG_V6_LOW:  prdata = cfg_ff.v6_low;
         REG_V6_EN:   prdata = {63'd0, cfg_ff.v6_en};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/pcsc_ctrl.sv =====
// Controller: accepts requests and sequences the per-class readout.
// Depends on pcsc_pkg for the command and status structs.
module pcsc_ctrl import pcsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_func,
   output logic         req_ready,
   input  pcsc_sts_type sts,
   output pcsc_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic               state_ff, state_in;
   logic [CLASS_W-1:0] idx_ff, idx_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func) begin
                  cmd.load_ts = 1'b1;
                  idx_in      = '0;
                  state_in    = ST_READ;
               end else begin
                  cmd.count_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            // advance one class each time the output register can take it
            if (sts.out_free) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_idx = idx_ff;
               if (idx_ff == LAST_CLASS) begin
                  cmd.rd_last   = 1'b1;
                  cmd.commit_ts = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/pcsc_dp.sv =====
// Datapath: classifier, counter bank, interval stamp and response register.
// Depends on pcsc_pkg and the response channel interface.
module pcsc_dp import pcsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pcsc_cmd_type       cmd,
   output pcsc_sts_type       sts,
   input  pcsc_cfg_type       cfg,
   input  logic [15:0]        pkt_length,
   input  logic [1:0]         direction,
   input  logic               is_ip,
   input  logic [3:0]         ip_version,
   input  logic [1:0]         transport,
   input  logic [7:0]         tcp_ctl_bits,
   input  logic [15:0]        remote_port,
   input  logic [63:0]        remote_addr_high,
   input  logic [63:0]        remote_addr_low,
   input  logic               addr_is_v6,
   input  logic [STAMP_W-1:0] new_timestamp,
   pcsc_rsp_if.source         rsp_ch
);

   logic [CNT_W-1:0]   pkt_cnt_ff  [NUM_CLASSES];
   logic [CNT_W-1:0]   byte_cnt_ff [NUM_CLASSES];
   logic [STAMP_W-1:0] stamp_ff, stamp_next_ff;
   logic [NUM_CLASSES-1:0] hit;
   logic known_dir, is_tcp, srv_match;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0] rsp_cat_ff;
   logic [CNT_W-1:0]   rsp_pkt_ff, rsp_byte_ff;
   logic [STAMP_W-1:0] rsp_stamp_ff;
   logic               rsp_last_ff;

   // classify the request
   always_comb begin
      known_dir = (direction == DIR_IN) || (direction == DIR_OUT);
      is_tcp    = is_ip && (transport == TR_TCP);
      if (addr_is_v6) begin
         srv_match = cfg.v6_en && (remote_addr_high == cfg.v6_high) &&
                     (remote_addr_low == cfg.v6_low);
      end else begin
         srv_match = cfg.v4_en && (remote_addr_low[31:0] == cfg.v4_addr);
      end
      hit            = '0;
      hit[C_ANY]     = 1'b1;
      hit[C_IN]      = (direction == DIR_IN);
      hit[C_OUT]     = (direction == DIR_OUT);
      hit[C_V4]      = is_ip && (ip_version == IP_VER_4);
      hit[C_V6]      = is_ip && (ip_version == IP_VER_6);
      hit[C_TCP]     = is_tcp;
      hit[C_UDP]     = is_ip && (transport == TR_UDP);
      hit[C_ICMP]    = is_ip && (transport == TR_ICMP);
      hit[C_SYN]     = is_tcp && tcp_ctl_bits[FL_SYN];
      hit[C_FIN]     = is_tcp && tcp_ctl_bits[FL_FIN];
      hit[C_SYNACK]  = is_tcp && tcp_ctl_bits[FL_SYN] && tcp_ctl_bits[FL_ACK];
      hit[C_ACK]     = is_tcp && tcp_ctl_bits[FL_ACK];
      hit[C_PSH]     = is_tcp && tcp_ctl_bits[FL_PSH];
      hit[C_LOWPORT] = is_ip && known_dir && (remote_port != 16'd0) &&
                       (remote_port <= LOW_PORT_MAX);
      hit[C_SERVER]  = is_ip && known_dir && srv_match &&
                       (remote_port != EXCLUDED_PORT);
   end

   // bump matching classes; clear each class as it is read out
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            pkt_cnt_ff[i]  <= '0;
            byte_cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            if (cmd.count_en && hit[i]) begin
               pkt_cnt_ff[i]  <= pkt_cnt_ff[i] + 1'b1;
               byte_cnt_ff[i] <= byte_cnt_ff[i] + CNT_W'(pkt_length);
            end else if (cmd.rd_en && (cmd.rd_idx == CLASS_W'(i))) begin
               pkt_cnt_ff[i]  <= '0;
               byte_cnt_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else if (cmd.commit_ts) begin
         stamp_ff <= stamp_next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ts) begin
         stamp_next_ff <= new_timestamp;
      end
   end

   // response register
   assign sts.out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rsp_cat_ff   <= cmd.rd_idx;
         rsp_pkt_ff   <= pkt_cnt_ff[cmd.rd_idx];
         rsp_byte_ff  <= byte_cnt_ff[cmd.rd_idx];
         rsp_stamp_ff <= stamp_ff;
         rsp_last_ff  <= cmd.rd_last;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.category       = rsp_cat_ff;
   assign rsp_ch.packet_total   = rsp_pkt_ff;
   assign rsp_ch.byte_total     = rsp_byte_ff;
   assign rsp_ch.interval_start = rsp_stamp_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

// ===== rtl/packet_class_stats_counters.sv =====
// Channel   | Direction | Carries
// req_ch    | in        | count request (func 0) or readout request (func 1)
// rsp_ch    | out       | one class pair per response, last on the final class
// psel etc. | in/out    | APB register port, server address match settings
//
// A count request is taken while idle; back-to-back count requests go at one per cycle outside a readout.
// A readout request gives 15 responses, at most one per cycle, paced by the single
// response register; new requests wait until the last one is loaded.
// Reset is synchronous; no clearing pass is needed.
// A stalled response holds its register and the readout sequence with it.
// Top level of the per-class packet and byte counters.
// Depends on pcsc_pkg, the channel interfaces, pcsc_csr, pcsc_ctrl and pcsc_dp.
module packet_class_stats_counters import pcsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pcsc_req_if.sink              req_ch,
   pcsc_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready
);

   pcsc_cfg_type cfg;
   pcsc_cmd_type cmd;
   pcsc_sts_type sts;

   pcsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcsc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg),
      .pkt_length       (req_ch.pkt_length),
      .direction        (req_ch.direction),
      .is_ip            (req_ch.is_ip),
      .ip_version       (req_ch.ip_version),
      .transport        (req_ch.transport),
      .tcp_ctl_bits     (req_ch.tcp_ctl_bits),
      .remote_port      (req_ch.remote_port),
      .remote_addr_high (req_ch.remote_addr_high),
      .remote_addr_low  (req_ch.remote_addr_low),
      .addr_is_v6       (req_ch.addr_is_v6),
      .new_timestamp    (req_ch.new_timestamp),
      .rsp_ch           (rsp_ch)
   );

endmodule

// ===== rtl/pcsc_checker.sv =====
// Port-level checks for the per-class counters, bound to the top level.
// Depends on pcsc_pkg for the class count.
module pcsc_checker import pcsc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_func,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [CLASS_W-1:0] rsp_category,
   input logic               rsp_last,
   input logic               pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_last_cat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_category == LAST_CLASS)
      else $error("last flag on a class other than the final one");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func |=> !req_ready)
      else $error("request taken at the start of a readout");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last &&
      rsp_category != CLASS_W'(NUM_CLASSES - 2) |=> !req_ready)
      else $error("request taken in the middle of a readout");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind packet_class_stats_counters pcsc_checker u_pcsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_func     (req_ch.func),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_category (rsp_ch.category),
   .rsp_last     (rsp_ch.last),
   .pready       (pready)
);
